/* sv/zst_pkg.sv */
`timescale 1ns / 1ps

package zst_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int CA_W       = $clog2(MAX_WIDTH);
  localparam int RA_W       = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 8;
  localparam int MIN_DIM    = 4;

  // item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PASSES = 2'd2;
  localparam logic [1:0] REG_SKEL   = 2'd3;

  // pass kinds
  localparam logic [1:0] KIND_SP0 = 2'd0;
  localparam logic [1:0] KIND_SP1 = 2'd1;
  localparam logic [1:0] KIND_BR  = 2'd2;

  // 3x3 window, bit 0 is column c-1
  typedef struct packed {
    logic [2:0] top;
    logic [2:0] mid;
    logic [2:0] bot;
  } zst_win_t;

  typedef struct packed {
    logic sub_pass;
    logic skel;
  } zst_ctl_t;

  typedef struct packed {
    logic thin_mark;
    logic branch_set;
  } zst_eval_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int lim);
    logic [DIM_W-1:0] res;
    res = v;
    if (int'(v) < MIN_DIM) res = DIM_W'(MIN_DIM);
    else if (int'(v) > lim) res = DIM_W'(lim);
    return res;
  endfunction

  function automatic logic [MAX_WIDTH-1:0] col_mask(input logic [DIM_W-1:0] w);
    logic [MAX_WIDTH-1:0] m;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      m[i] = (i < int'(w));
    end
    return m;
  endfunction

endpackage

/* sv/zhang_suen_thinning.sv */
`timescale 1ns / 1ps

// Binary image thinning engine. Load items write one pixel (grey >= 128 is
// foreground) and read items return the thinned and branch images at one
// position; both go through the row memory. A run item sweeps the image row
// by row with a single 3x3 neighbourhood evaluator, one column per cycle; a
// run makes 2*P + 1 sweeps for P pass pairs (the last one builds the branch
// image), and no item is taken until it finishes.
module zhang_suen_thinning (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[1:0], row[8:2], col[15:9], pixel[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // skeleton_pixel[7:0], branch_pixel[15:8], passes_done[23:16]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int MW   = zst_pkg::MAX_WIDTH;
  localparam int MH   = zst_pkg::MAX_HEIGHT;
  localparam int CA_W = zst_pkg::CA_W;
  localparam int RA_W = zst_pkg::RA_W;
  localparam int DW   = zst_pkg::DIM_W;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_LD_RD  = 5'd1;
  localparam logic [4:0] ST_LD_WR  = 5'd2;
  localparam logic [4:0] ST_RD_RD  = 5'd3;
  localparam logic [4:0] ST_RD_TK  = 5'd4;
  localparam logic [4:0] ST_TOP_RD = 5'd5;
  localparam logic [4:0] ST_TOP_TK = 5'd6;
  localparam logic [4:0] ST_MID_RD = 5'd7;
  localparam logic [4:0] ST_MID_TK = 5'd8;
  localparam logic [4:0] ST_BOT_RD = 5'd9;
  localparam logic [4:0] ST_BOT_TK = 5'd10;
  localparam logic [4:0] ST_COL    = 5'd11;
  localparam logic [4:0] ST_WB     = 5'd12;
  localparam logic [4:0] ST_PEND   = 5'd13;
  localparam logic [4:0] ST_BR_E0  = 5'd14;
  localparam logic [4:0] ST_BR_E1  = 5'd15;
  localparam logic [4:0] ST_RESP   = 5'd16;

  logic [4:0]      state_r, state_nxt;

  logic [DW-1:0]   width_r, height_r, maxp_r;
  logic            skel_r;
  logic [DW-1:0]   wu, hu;
  logic [MW-1:0]   wmask;

  logic [1:0]      mode_r;
  logic [RA_W-1:0] row_r;
  logic [CA_W-1:0] col_r;
  logic            fg_r;
  logic            res_skel_r, res_br_r;
  logic [7:0]      pc_r;
  logic [1:0]      kind_r;
  logic            cleared_r, anyfg_r;
  logic [RA_W-1:0] r_r;
  logic [CA_W-1:0] c_r;
  logic [MW-1:0]   top_r, mid_r, bot_r, o_r;
  logic            out_valid_r;
  logic [23:0]     out_data_r;

  logic [MW-1:0]   img_mem [MH];
  logic [MW-1:0]   br_mem  [MH];
  logic [MW-1:0]   img_q_r, br_q_r;
  logic            img_re, img_we, br_re, br_we;
  logic [RA_W-1:0] img_ra, img_wa, br_wa;
  logic [MW-1:0]   img_wd, br_wd;

  logic [1:0]      in_mode;
  logic [RA_W-1:0] in_row;
  logic [CA_W-1:0] in_col;
  logic [7:0]      in_pixel;
  logic            in_inside;
  logic            in_acc;
  logic            resp_free;

  logic [CA_W-1:0] c_m1, c_p1;
  logic            last_col, last_row;
  logic [7:0]      pc_inc;
  logic            pair_more;

  zst_pkg::zst_win_t  win;
  zst_pkg::zst_ctl_t  ctl;
  zst_pkg::zst_eval_t ev;

  assign wu    = zst_pkg::clamp_dim(width_r, MW);
  assign hu    = zst_pkg::clamp_dim(height_r, MH);
  assign wmask = zst_pkg::col_mask(wu);

  assign in_mode   = in_tdata[1:0];
  assign in_row    = in_tdata[8:2];
  assign in_col    = in_tdata[15:9];
  assign in_pixel  = in_tdata[23:16];
  assign in_inside = ({1'b0, in_row} < hu) && ({1'b0, in_col} < wu);

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign resp_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign c_m1     = c_r - CA_W'(1);
  assign c_p1     = c_r + CA_W'(1);
  assign last_col = ({1'b0, c_r} == wu - DW'(2));
  assign last_row = ({1'b0, r_r} == hu - DW'(2));
  assign pc_inc   = pc_r + 8'd1;
  assign pair_more = ((pc_r == 8'd0) ? anyfg_r : cleared_r) && (pc_inc < maxp_r);

  assign win.top = {top_r[c_p1], top_r[c_r], top_r[c_m1]};
  assign win.mid = {mid_r[c_p1], mid_r[c_r], mid_r[c_m1]};
  assign win.bot = {bot_r[c_p1], bot_r[c_r], bot_r[c_m1]};
  assign ctl.sub_pass = (kind_r == zst_pkg::KIND_SP1);
  assign ctl.skel     = skel_r;

  zst_nbhd u_nbhd (
    .win (win),
    .ctl (ctl),
    .ev  (ev)
  );

  // row memories
  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_wa] <= img_wd;
    if (img_re) img_q_r <= img_mem[img_ra];
  end

  // branch rows: only columns in use are touched
  always_ff @(posedge clk) begin
    if (br_we) begin
      for (int i = 0; i < MW; i++) begin
        if (wmask[i]) br_mem[br_wa][i] <= br_wd[i];
      end
    end
    if (br_re) br_q_r <= br_mem[img_ra];
  end

  always_comb begin
    img_re = 1'b0;
    img_we = 1'b0;
    br_re  = 1'b0;
    br_we  = 1'b0;
    img_ra = row_r;
    img_wa = r_r;
    img_wd = o_r;
    br_wa  = r_r;
    br_wd  = o_r;
    case (state_r)
      ST_LD_RD: begin
        img_re = 1'b1;
      end
      ST_LD_WR: begin
        img_we = 1'b1;
        img_wa = row_r;
        img_wd = img_q_r;
        img_wd[col_r] = fg_r;
      end
      ST_RD_RD: begin
        img_re = 1'b1;
        br_re  = 1'b1;
      end
      ST_TOP_RD: begin
        img_re = 1'b1;
        img_ra = '0;
      end
      ST_MID_RD: begin
        img_re = 1'b1;
        img_ra = RA_W'(1);
      end
      ST_BOT_RD: begin
        img_re = 1'b1;
        img_ra = r_r + RA_W'(1);
      end
      ST_WB: begin
        if (kind_r == zst_pkg::KIND_BR) br_we = 1'b1;
        else img_we = 1'b1;
      end
      ST_BR_E0: begin
        br_we = 1'b1;
        br_wa = '0;
        br_wd = '0;
      end
      ST_BR_E1: begin
        br_we = 1'b1;
        br_wa = RA_W'(hu - DW'(1));
        br_wd = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            zst_pkg::MODE_LOAD: state_nxt = in_inside ? ST_LD_RD : ST_RESP;
            zst_pkg::MODE_RUN:  state_nxt = ST_TOP_RD;
            zst_pkg::MODE_READ: state_nxt = in_inside ? ST_RD_RD : ST_RESP;
            default:            state_nxt = ST_RESP;
          endcase
        end
      end
      ST_LD_RD:  state_nxt = ST_LD_WR;
      ST_LD_WR:  state_nxt = ST_RESP;
      ST_RD_RD:  state_nxt = ST_RD_TK;
      ST_RD_TK:  state_nxt = ST_RESP;
      ST_TOP_RD: state_nxt = ST_TOP_TK;
      ST_TOP_TK: state_nxt = ST_MID_RD;
      ST_MID_RD: state_nxt = ST_MID_TK;
      ST_MID_TK: state_nxt = ST_BOT_RD;
      ST_BOT_RD: state_nxt = ST_BOT_TK;
      ST_BOT_TK: state_nxt = ST_COL;
      ST_COL:    state_nxt = last_col ? ST_WB : ST_COL;
      ST_WB:     state_nxt = last_row ? ST_PEND : ST_BOT_RD;
      ST_PEND:   state_nxt = (kind_r == zst_pkg::KIND_BR) ? ST_BR_E0 : ST_TOP_RD;
      ST_BR_E0:  state_nxt = ST_BR_E1;
      ST_BR_E1:  state_nxt = ST_RESP;
      ST_RESP:   state_nxt = resp_free ? ST_IDLE : ST_RESP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      width_r     <= DW'(MW);
      height_r    <= DW'(MH);
      maxp_r      <= 8'd255;
      skel_r      <= 1'b1;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          zst_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
          zst_pkg::REG_HEIGHT: height_r <= cfg_wdata;
          zst_pkg::REG_PASSES: maxp_r   <= cfg_wdata;
          zst_pkg::REG_SKEL:   skel_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      if (state_r == ST_RESP && resp_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {pc_r, {8{res_br_r}}, {8{res_skel_r}}};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            mode_r     <= in_mode;
            row_r      <= in_row;
            col_r      <= in_col;
            fg_r       <= in_pixel[7];
            res_skel_r <= 1'b0;
            res_br_r   <= 1'b0;
            if (in_mode == zst_pkg::MODE_RUN) begin
              pc_r      <= '0;
              kind_r    <= zst_pkg::KIND_SP0;
              cleared_r <= 1'b0;
            end
          end
        end
        ST_RD_TK: begin
          res_skel_r <= img_q_r[col_r];
          res_br_r   <= br_q_r[col_r];
        end
        ST_TOP_TK: begin
          top_r <= img_q_r;
          if (kind_r == zst_pkg::KIND_SP1) anyfg_r <= |(img_q_r & wmask);
        end
        ST_MID_TK: begin
          mid_r <= img_q_r;
          o_r   <= (kind_r == zst_pkg::KIND_BR) ? '0 : img_q_r;
          r_r   <= RA_W'(1);
        end
        ST_BOT_TK: begin
          bot_r <= img_q_r;
          c_r   <= CA_W'(1);
        end
        ST_COL: begin
          if (kind_r == zst_pkg::KIND_BR) begin
            o_r[c_r] <= ev.branch_set;
          end else if (ev.thin_mark) begin
            o_r[c_r]  <= 1'b0;
            cleared_r <= cleared_r | mid_r[c_r];
          end
          c_r <= c_p1;
        end
        ST_WB: begin
          if (kind_r == zst_pkg::KIND_SP1) begin
            anyfg_r <= anyfg_r | (|(o_r & wmask)) | (last_row && (|(bot_r & wmask)));
          end
          if (!last_row) begin
            top_r <= mid_r;
            mid_r <= bot_r;
            o_r   <= (kind_r == zst_pkg::KIND_BR) ? '0 : bot_r;
            r_r   <= r_r + RA_W'(1);
          end
        end
        ST_PEND: begin
          if (kind_r == zst_pkg::KIND_SP0) begin
            kind_r <= zst_pkg::KIND_SP1;
          end else if (kind_r == zst_pkg::KIND_SP1) begin
            pc_r <= pc_inc;
            if (pair_more) begin
              kind_r    <= zst_pkg::KIND_SP0;
              cleared_r <= 1'b0;
            end else begin
              kind_r <= zst_pkg::KIND_BR;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL) |-> (c_r != '0 && {1'b0, c_r} <= wu - DW'(2)))
    else $error("column index outside interior");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (r_r != '0 && {1'b0, r_r} <= hu - DW'(2)))
    else $error("row index outside interior");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item taken while busy");

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PEND && kind_r == zst_pkg::KIND_SP1) |-> (pc_r < maxp_r || pc_r == 8'd0))
    else $error("pass pair count beyond limit");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && mode_r != zst_pkg::MODE_READ) |-> (out_data_r[15:0] == 16'd0))
    else $error("pixel data on non-read item");
`endif

endmodule

/* sv/zst_nbhd.sv */
`timescale 1ns / 1ps

module zst_nbhd (
  input  zst_pkg::zst_win_t  win,
  input  zst_pkg::zst_ctl_t  ctl,
  output zst_pkg::zst_eval_t ev
);

  logic [7:0] nb;
  logic [3:0] a_cnt;
  logic [3:0] b_cnt;
  logic [3:0] b_min;
  logic       m1;
  logic       m2;

  // ring order N, NE, E, SE, S, SW, W, NW
  assign nb = {win.top[0], win.mid[0], win.bot[0], win.bot[1],
               win.bot[2], win.mid[2], win.top[2], win.top[1]};

  always_comb begin
    a_cnt = '0;
    b_cnt = '0;
    for (int k = 0; k < 8; k++) begin
      a_cnt = a_cnt + {3'd0, (!nb[k] && nb[(k + 1) % 8])};
      b_cnt = b_cnt + {3'd0, nb[k]};
    end
  end

  always_comb begin
    if (ctl.sub_pass) begin
      m1 = nb[0] & nb[2] & nb[6];
      m2 = nb[0] & nb[4] & nb[6];
    end else begin
      m1 = nb[0] & nb[2] & nb[4];
      m2 = nb[2] & nb[4] & nb[6];
    end
  end

  assign b_min = ctl.skel ? 4'd2 : 4'd1;

  assign ev.thin_mark  = (a_cnt == 4'd1) && (b_cnt >= b_min) && (b_cnt <= 4'd6) && !m1 && !m2;
  assign ev.branch_set = win.mid[1] && ((a_cnt >= 4'd3) || (a_cnt == 4'd2 && b_cnt == 4'd6));

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] MODE_NOP    = 2'd3;
  localparam int         B_MAX       = 6;
  localparam int         BRANCH_A    = 3;
  localparam logic [7:0] PIX_ON      = 8'd255;
  localparam int         ITEM_TARGET = 1450;
  localparam int         STALL_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // mode[1:0], row[8:2], col[15:9], pixel[23:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // skeleton_pixel[7:0], branch_pixel[15:8], passes_done[23:16]
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;

  zhang_suen_thinning i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  class thin_scoreboard;
    bit          img  [zst_pkg::MAX_HEIGHT][zst_pkg::MAX_WIDTH];
    bit          brn  [zst_pkg::MAX_HEIGHT][zst_pkg::MAX_WIDTH];
    bit          mark [zst_pkg::MAX_HEIGHT][zst_pkg::MAX_WIDTH];
    logic [7:0]  reg_w;
    logic [7:0]  reg_h;
    logic [7:0]  reg_passes;
    logic        reg_skel;
    logic [7:0]  pair_count;
    logic [23:0] expected_q[$];
    int          fails;

    function new();
      reg_w      = 8'd128;
      reg_h      = 8'd128;
      reg_passes = 8'd255;
      reg_skel   = 1'b1;
      pair_count = '0;
      fails      = 0;
    endfunction

    function int dim_used(logic [7:0] v, int lim);
      if (int'(v) < zst_pkg::MIN_DIM) return zst_pkg::MIN_DIM;
      if (int'(v) > lim) return lim;
      return int'(v);
    endfunction

    function int cols_used();
      return dim_used(reg_w, zst_pkg::MAX_WIDTH);
    endfunction

    function int rows_used();
      return dim_used(reg_h, zst_pkg::MAX_HEIGHT);
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        zst_pkg::REG_WIDTH:  reg_w = v;
        zst_pkg::REG_HEIGHT: reg_h = v;
        zst_pkg::REG_PASSES: reg_passes = v;
        zst_pkg::REG_SKEL:   reg_skel = v[0];
        default: ;
      endcase
    endfunction

    // ring bit 0 is N, then clockwise to NW
    function void ring_of(int r, int c, output int a, output int b, output bit [7:0] nb);
      nb = {img[r-1][c-1], img[r][c-1], img[r+1][c-1], img[r+1][c],
            img[r+1][c+1], img[r][c+1], img[r-1][c+1], img[r-1][c]};
      a = 0;
      for (int k = 0; k < 8; k++) begin
        if (!nb[k] && nb[(k + 1) % 8]) a++;
      end
      b = $countones(nb);
    endfunction

    function bit sweep(bit second);
      int       h, w, r, c, a, b;
      bit [7:0] nb;
      bit       m1, m2, hit;
      h   = rows_used();
      w   = cols_used();
      hit = 1'b0;
      for (r = 0; r < h; r++) for (c = 0; c < w; c++) mark[r][c] = 1'b0;
      for (r = 1; r + 1 < h; r++) begin
        for (c = 1; c + 1 < w; c++) begin
          ring_of(r, c, a, b, nb);
          if (!second) begin
            m1 = nb[0] & nb[2] & nb[4];
            m2 = nb[2] & nb[4] & nb[6];
          end else begin
            m1 = nb[0] & nb[2] & nb[6];
            m2 = nb[0] & nb[4] & nb[6];
          end
          mark[r][c] = (a == 1) && (b >= (reg_skel ? 2 : 1)) && (b <= B_MAX) && !m1 && !m2;
        end
      end
      for (r = 0; r < h; r++) begin
        for (c = 0; c < w; c++) begin
          if (mark[r][c] && img[r][c]) begin
            img[r][c] = 1'b0;
            hit = 1'b1;
          end
        end
      end
      return hit;
    endfunction

    function void note_item(logic [23:0] d);
      logic [1:0] md;
      logic [6:0] row, col;
      logic [7:0] pix, sk, br;
      int         h, w, r, c, a, b, left;
      bit         opening, c0, c1, busy;
      bit [7:0]   nb;
      md  = d[1:0];
      row = d[8:2];
      col = d[15:9];
      pix = d[23:16];
      h   = rows_used();
      w   = cols_used();
      sk  = '0;
      br  = '0;
      case (md)
        zst_pkg::MODE_LOAD: begin
          if (row < h && col < w) img[row][col] = pix[7];
        end
        zst_pkg::MODE_RUN: begin
          left       = reg_passes;
          opening    = 1'b1;
          pair_count = '0;
          do begin
            c0 = sweep(1'b0);
            c1 = sweep(1'b1);
            pair_count = pair_count + 8'd1;
            busy = c0 || c1;
            // first pair is judged against an empty image
            if (opening) begin
              busy = 1'b0;
              for (r = 0; r < h; r++) for (c = 0; c < w; c++) if (img[r][c]) busy = 1'b1;
            end
            opening = 1'b0;
            if (left > 0) left--;
          end while (busy && left > 0);
          for (r = 0; r < h; r++) for (c = 0; c < w; c++) brn[r][c] = 1'b0;
          for (r = 1; r + 1 < h; r++) begin
            for (c = 1; c + 1 < w; c++) begin
              if (img[r][c]) begin
                ring_of(r, c, a, b, nb);
                if (a >= BRANCH_A || (a == 2 && b == B_MAX)) brn[r][c] = 1'b1;
              end
            end
          end
        end
        zst_pkg::MODE_READ: begin
          if (row < h && col < w) begin
            sk = img[row][col] ? PIX_ON : 8'd0;
            br = brn[row][col] ? PIX_ON : 8'd0;
          end
        end
        default: ;
      endcase
      expected_q.push_back({pair_count, br, sk});
    endfunction

    task report(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      fails++;
    endtask

    task check_result(logic [23:0] d);
      logic [23:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with no item waiting", d));
      end else begin
        want = expected_q.pop_front();
        if (d[7:0] != want[7:0])
          report($sformatf("skeleton pixel got %0d want %0d", d[7:0], want[7:0]));
        if (d[15:8] != want[15:8])
          report($sformatf("branch pixel got %0d want %0d", d[15:8], want[15:8]));
        if (d[23:16] != want[23:16])
          report($sformatf("pair count got %0d want %0d", d[23:16], want[23:16]));
      end
    endtask
  endclass

  thin_scoreboard sb;

  bit img_ok [zst_pkg::MAX_HEIGHT][zst_pkg::MAX_WIDTH];
  bit br_ok  [zst_pkg::MAX_HEIGHT][zst_pkg::MAX_WIDTH];
  bit scene  [zst_pkg::MAX_HEIGHT][zst_pkg::MAX_WIDTH];
  int cur_w       = zst_pkg::MAX_WIDTH;
  int cur_h       = zst_pkg::MAX_HEIGHT;
  int burst_left  = 0;
  int items_sent  = 0;
  int hold_reqs   = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_reg(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) sb.note_item(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stall styles of random length, plus long hold-offs on request
  initial begin : rx_proc
    int style, style_left, hold_left, hold_seen;
    style      = 0;
    style_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = $urandom_range(300, 500);
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(32, 256);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (style_left % 5 < 3);
        endcase
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 8'(val);
  endtask

  task automatic set_config(input int w, input int h, input int p, input int s);
    wait_idle();
    write_reg(zst_pkg::REG_WIDTH, w);
    write_reg(zst_pkg::REG_HEIGHT, h);
    write_reg(zst_pkg::REG_PASSES, p);
    write_reg(zst_pkg::REG_SKEL, s);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_w = sb.cols_used();
    cur_h = sb.rows_used();
  endtask

  task automatic send_item(input logic [1:0] md, input int row, input int col, input int pix);
    int  gap, r, c;
    bit  inside_rgn;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {8'(pix), 7'(col), 7'(row), md};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    inside_rgn = row < cur_h && col < cur_w;
    if (md == zst_pkg::MODE_LOAD && inside_rgn) img_ok[row][col] = 1'b1;
    if (md == zst_pkg::MODE_RUN) begin
      for (r = 0; r < cur_h; r++) for (c = 0; c < cur_w; c++) br_ok[r][c] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_item(MODE_NOP, $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 255));
    else if (cur_h < zst_pkg::MAX_HEIGHT)
      send_item(zst_pkg::MODE_LOAD, $urandom_range(cur_h, 127), $urandom_range(0, 127),
                $urandom_range(0, 255));
    else if (cur_w < zst_pkg::MAX_WIDTH)
      send_item(zst_pkg::MODE_LOAD, $urandom_range(0, 127), $urandom_range(cur_w, 127),
                $urandom_range(0, 255));
    else
      send_item(MODE_NOP, $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 255));
  endtask

  // only positions already written, or outside the region
  task automatic read_some(input int n);
    int r, c, tries;
    repeat (n) begin
      for (tries = 0; tries < 20; tries++) begin
        if ($urandom_range(0, 3) == 0) begin
          r = $urandom_range(0, 127);
          c = $urandom_range(0, 127);
        end else begin
          r = $urandom_range(0, cur_h - 1);
          c = $urandom_range(0, cur_w - 1);
        end
        if (r >= cur_h || c >= cur_w || (img_ok[r][c] && br_ok[r][c])) begin
          send_item(zst_pkg::MODE_READ, r, c, $urandom_range(0, 255));
          break;
        end
      end
    end
  endtask

  task automatic fill_region();
    int style, r, c, r0, c0, rh, cw;
    style = $urandom_range(0, 9);
    for (r = 0; r < cur_h; r++) begin
      for (c = 0; c < cur_w; c++) begin
        scene[r][c] = (style == 1 || style == 2) ? 1'($urandom_range(0, 1)) : 1'b0;
      end
    end
    // blocks and bars with a sprinkle of noise
    if (style >= 3) begin
      repeat ($urandom_range(1, 4)) begin
        rh = $urandom_range(0, 1) ? $urandom_range(1, cur_h) : $urandom_range(1, 3);
        cw = $urandom_range(0, 1) ? $urandom_range(1, cur_w) : $urandom_range(1, 3);
        r0 = $urandom_range(0, cur_h - rh);
        c0 = $urandom_range(0, cur_w - cw);
        for (r = r0; r < r0 + rh; r++) for (c = c0; c < c0 + cw; c++) scene[r][c] = 1'b1;
      end
      for (r = 0; r < cur_h; r++) begin
        for (c = 0; c < cur_w; c++) begin
          if ($urandom_range(0, 15) == 0) scene[r][c] = !scene[r][c];
        end
      end
    end
    for (r = 0; r < cur_h; r++) begin
      for (c = 0; c < cur_w; c++) begin
        if ($urandom_range(0, 24) == 0) send_noise();
        send_item(zst_pkg::MODE_LOAD, r, c,
                  scene[r][c] ? $urandom_range(128, 255) : $urandom_range(0, 127));
      end
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(13, 20);
      default: return $urandom_range(4, 12);
    endcase
  endfunction

  function automatic int pick_passes();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return 255;
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  task automatic run_phase(input int ph);
    if (ph == 0) set_config(255, 4, 255, $urandom_range(0, 1));
    else set_config(pick_dim(), pick_dim(), pick_passes(), $urandom_range(0, 1));
    if (ph % 8 == 2) hold_reqs++;
    fill_region();
    send_item(zst_pkg::MODE_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
              $urandom_range(0, 255));
    read_some($urandom_range(6, 20));
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 6))
          send_item(zst_pkg::MODE_LOAD, $urandom_range(0, cur_h - 1),
                    $urandom_range(0, cur_w - 1), $urandom_range(0, 255));
      end
      send_item(zst_pkg::MODE_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 255));
      read_some($urandom_range(4, 12));
    end
  endtask

  task automatic scatter_phase(input bit tall);
    if (tall) set_config(128, 255, pick_passes(), $urandom_range(0, 255));
    else set_config($urandom_range(0, 255), $urandom_range(0, 255), pick_passes(),
                    $urandom_range(0, 255));
    repeat ($urandom_range(20, 50)) begin
      case ($urandom_range(0, 9))
        0: send_noise();
        1, 2, 3: read_some(1);
        default: send_item(zst_pkg::MODE_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 255));
      endcase
    end
  endtask

  initial begin : stim_proc
    int grey [16];
    int k, phase;
    grey = '{0, 255, 128, 127, 200, 129, 1, 126, 64, 250, 130, 128, 0, 127, 255, 12};
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // 4x4 image by clamping, zero pair limit, shrink rule
    set_config(3, 0, 0, 0);
    send_item(MODE_NOP, 127, 127, 255);
    for (k = 0; k < 16; k++) send_item(zst_pkg::MODE_LOAD, k / 4, k % 4, grey[k]);
    send_item(zst_pkg::MODE_LOAD, 127, 127, 255);
    send_item(zst_pkg::MODE_RUN, 0, 0, 0);
    send_item(zst_pkg::MODE_READ, 0, 0, 0);
    send_item(zst_pkg::MODE_READ, 1, 1, 0);
    send_item(zst_pkg::MODE_READ, 2, 2, 0);
    send_item(zst_pkg::MODE_READ, 3, 3, 0);
    send_item(zst_pkg::MODE_READ, 127, 127, 255);
    send_item(zst_pkg::MODE_RUN, 127, 127, 255);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase % 6 == 4) scatter_phase(phase == 4);
      else run_phase(phase);
      phase++;
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d items left without a result", sb.expected_q.size()));
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
